/* rtl/analog_key_rapid_trigger_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the analog key rapid trigger
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ANALOG_KEY_RAPID_TRIGGER_DEFINES_SVH
`define ANALOG_KEY_RAPID_TRIGGER_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define AKRT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("akrt: same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define AKRT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("akrt: next-cycle check failed");

// Next-cycle implication that is checked through reset as well.
`define AKRT_ASSERT_RESET(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("akrt: reset check failed");

`endif

/* rtl/akrt_pkg.sv */
// ----------------------------------------------------------------------------
// Analog key rapid trigger package
// Widths, register codes, key modes and the beat types passed between stages.
// ----------------------------------------------------------------------------
package akrt_pkg;

   localparam int RawW     = 16;
   localparam int LevelW   = 18;
   localparam int DistW    = 17;
   localparam int HystW    = 16;
   localparam int SpeedW   = 18;
   localparam int InvW     = 32;
   localparam int FracW    = 16;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 32;

   // Difference (RawW+1) times unsigned reciprocal (InvW+1 as signed).
   localparam int ProdW  = RawW + 1 + InvW + 1;
   localparam int QuotW  = ProdW - FracW;
   // Wide enough for level minus mark minus hysteresis without overflow.
   localparam int CalcW  = LevelW + 3;

   typedef logic signed [LevelW-1:0] level_type;

   localparam level_type LevelMax   = level_type'(131071);
   localparam level_type LevelMin   = level_type'(-131072);
   localparam level_type FullTravel = level_type'(65536);
   localparam level_type LevelZero  = level_type'(0);

   typedef enum logic [1:0] {
      MODE_DIGITAL,
      MODE_THRESHOLD,
      MODE_RAPID,
      MODE_SPEED
   } mode_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_MODE,
      CSR_TOP_LEVEL,
      CSR_INV_RANGE,
      CSR_TRIGGER_DIST,
      CSR_RELEASE_DIST,
      CSR_HYSTERESIS,
      CSR_TRIGGER_SPEED,
      CSR_RELEASE_SPEED
   } csr_index_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [RawW-1:0]    top_level;
      logic [InvW-1:0]           inv_range;
      logic [DistW-1:0]          press_dist;
      logic [DistW-1:0]          lift_dist;
      logic [HystW-1:0]          hysteresis;
      logic signed [SpeedW-1:0]  press_rate;
      logic signed [SpeedW-1:0]  lift_rate;
   } cfg_type;

   typedef struct packed {
      level_type level;
      logic      raw_nonzero;
   } lvl_beat_type;

endpackage

/* rtl/akrt_csr.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register bank that holds the mode and the level/rule settings.
// ----------------------------------------------------------------------------
module akrt_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wen,
   input  logic [akrt_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [akrt_pkg::CsrDataW-1:0]  csr_wdata,
   output akrt_pkg::cfg_type              cfg
);
   import akrt_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:          cfg_in.mode       = mode_type'(csr_wdata[1:0]);
            CSR_TOP_LEVEL:     cfg_in.top_level  = $signed(csr_wdata[RawW-1:0]);
            CSR_INV_RANGE:     cfg_in.inv_range  = csr_wdata[InvW-1:0];
            CSR_TRIGGER_DIST:  cfg_in.press_dist = csr_wdata[DistW-1:0];
            CSR_RELEASE_DIST:  cfg_in.lift_dist  = csr_wdata[DistW-1:0];
            CSR_HYSTERESIS:    cfg_in.hysteresis = csr_wdata[HystW-1:0];
            CSR_TRIGGER_SPEED: cfg_in.press_rate = $signed(csr_wdata[SpeedW-1:0]);
            CSR_RELEASE_SPEED: cfg_in.lift_rate  = $signed(csr_wdata[SpeedW-1:0]);
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode       <= MODE_DIGITAL;
         cfg_ff.top_level  <= '0;
         cfg_ff.inv_range  <= '0;
         cfg_ff.press_dist <= DistW'(32768);
         cfg_ff.lift_dist  <= DistW'(32768);
         cfg_ff.hysteresis <= '0;
         cfg_ff.press_rate <= '0;
         cfg_ff.lift_rate  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/akrt_level.sv */
// ----------------------------------------------------------------------------
// Travel level stage
// Registers the raw sample, then scales it to a saturated Q16 level with one
// multiply by the reciprocal range.
// ----------------------------------------------------------------------------
module akrt_level (
   input  logic                              clock,
   input  logic                              reset,
   input  akrt_pkg::cfg_type                 cfg,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [akrt_pkg::RawW-1:0]  req_raw_sample,
   output logic                              lvl_valid,
   input  logic                              lvl_ready,
   output akrt_pkg::lvl_beat_type            lvl_beat
);
   import akrt_pkg::*;

   logic                   raw_valid_ff, raw_valid_in;
   logic signed [RawW-1:0] raw_ff, raw_in;
   logic                   beat_valid_ff, beat_valid_in;
   lvl_beat_type           beat_ff, beat_in;
   logic                   raw_ready, beat_ready;

   logic signed [RawW:0]    diff;
   logic signed [ProdW-1:0] prod;
   logic signed [QuotW-1:0] quot;

   // Each stage takes a beat when it is empty or its beat moves on.
   assign beat_ready = !beat_valid_ff || lvl_ready;
   assign raw_ready  = !raw_valid_ff || beat_ready;
   assign req_ready  = raw_ready;

   assign raw_valid_in  = raw_ready ? req_valid : raw_valid_ff;
   assign raw_in        = (req_valid && raw_ready) ? req_raw_sample : raw_ff;
   assign beat_valid_in = beat_ready ? raw_valid_ff : beat_valid_ff;

   always_comb begin
      diff = $signed({cfg.top_level[RawW-1], cfg.top_level})
             - $signed({raw_ff[RawW-1], raw_ff});
      prod = ProdW'(diff) * ProdW'($signed({1'b0, cfg.inv_range}));
      // Arithmetic shift gives the floor of the Q32 product in Q16.
      quot = prod[ProdW-1:FracW];

      beat_in = beat_ff;
      if (raw_valid_ff && beat_ready) begin
         beat_in.raw_nonzero = (raw_ff != '0);
         if (quot > QuotW'(LevelMax)) begin
            beat_in.level = LevelMax;
         end else if (quot < QuotW'(LevelMin)) begin
            beat_in.level = LevelMin;
         end else begin
            beat_in.level = quot[LevelW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_valid_ff  <= 1'b0;
         beat_valid_ff <= 1'b0;
      end else begin
         raw_valid_ff  <= raw_valid_in;
         beat_valid_ff <= beat_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff  <= raw_in;
      beat_ff <= beat_in;
   end

   assign lvl_valid = beat_valid_ff;
   assign lvl_beat  = beat_ff;

endmodule

/* rtl/akrt_rules.sv */
// ----------------------------------------------------------------------------
// Press and release rules
// Applies the digital, threshold, rapid trigger or speed rule to one level
// beat, updates the key state and holds the result beat for the consumer.
// ----------------------------------------------------------------------------
module akrt_rules (
   input  logic                    clock,
   input  logic                    reset,
   input  akrt_pkg::cfg_type       cfg,
   input  logic                    lvl_valid,
   output logic                    lvl_ready,
   input  akrt_pkg::lvl_beat_type  lvl_beat,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_pressed,
   output logic                    rsp_press_event,
   output akrt_pkg::level_type     rsp_level
);
   import akrt_pkg::*;

   logic      rsp_valid_ff, rsp_valid_in;
   logic      key_down_ff, key_down_in;
   logic      event_ff, event_in;
   level_type level_ff, level_in;
   level_type last_level_ff, last_level_in;
   level_type low_mark_ff, low_mark_in;
   level_type high_mark_ff, high_mark_in;
   logic      take;

   level_type               v;
   level_type               hi_step;
   logic signed [CalcW-1:0] lv_w, lo_w, h_w, td_w, rd_w, ts_w, rs_w, delta;
   logic                    up, down, press, release_now;

   assign lvl_ready    = !rsp_valid_ff || rsp_ready;
   assign take         = lvl_valid && lvl_ready;
   assign rsp_valid_in = lvl_ready ? lvl_valid : rsp_valid_ff;

   always_comb begin
      v    = lvl_beat.level;
      lv_w = CalcW'(v);
      lo_w = CalcW'(low_mark_ff);
      h_w  = CalcW'($signed({1'b0, cfg.hysteresis}));
      td_w = CalcW'($signed({1'b0, cfg.press_dist}));
      rd_w = CalcW'($signed({1'b0, cfg.lift_dist}));
      ts_w = CalcW'(cfg.press_rate);
      rs_w = CalcW'(cfg.lift_rate);
      delta = lv_w - CalcW'(last_level_ff);

      up          = (lv_w - lo_w - h_w >= td_w);
      press       = 1'b0;
      release_now = 1'b0;
      hi_step     = high_mark_ff;
      down        = 1'b0;

      key_down_in   = key_down_ff;
      event_in      = event_ff;
      level_in      = level_ff;
      last_level_in = last_level_ff;
      low_mark_in   = low_mark_ff;
      high_mark_in  = high_mark_ff;

      if (take) begin
         event_in      = 1'b0;
         level_in      = v;
         last_level_in = v;
         unique case (cfg.mode)
            MODE_DIGITAL: begin
               event_in      = !key_down_ff && lvl_beat.raw_nonzero;
               key_down_in   = lvl_beat.raw_nonzero;
               level_in      = LevelZero;
               last_level_in = last_level_ff;
            end
            MODE_THRESHOLD: begin
               press       = (lv_w - h_w > td_w);
               release_now = (lv_w + h_w < td_w);
               event_in    = press && !key_down_ff;
               key_down_in = (press || key_down_ff) && !release_now;
            end
            MODE_RAPID: begin
               // The release check sees the high mark as updated in this beat.
               if (key_down_ff) begin
                  hi_step = (up && v > high_mark_ff) ? v : high_mark_ff;
               end else begin
                  hi_step = up ? v : high_mark_ff;
               end
               down         = (CalcW'(hi_step) - lv_w - h_w >= rd_w);
               high_mark_in = hi_step;
               if (key_down_ff) begin
                  key_down_in = !down;
                  low_mark_in = down ? v : low_mark_ff;
               end else begin
                  key_down_in = up;
                  event_in    = up;
                  low_mark_in = (down && v < low_mark_ff) ? v : low_mark_ff;
               end
               // Full travel and zero travel override the tracked marks.
               if (v <= LevelZero) begin
                  key_down_in = 1'b0;
                  low_mark_in = LevelZero;
               end
               if (v >= FullTravel) begin
                  event_in     = event_in || !key_down_in;
                  key_down_in  = 1'b1;
                  high_mark_in = FullTravel;
               end
            end
            MODE_SPEED: begin
               press       = (delta > ts_w);
               release_now = (delta < rs_w);
               event_in    = press && !key_down_ff;
               key_down_in = (press || key_down_ff) && !release_now;
            end
            default: begin
               key_down_in = key_down_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         key_down_ff   <= 1'b0;
         last_level_ff <= LevelZero;
         low_mark_ff   <= LevelZero;
         high_mark_ff  <= LevelZero;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         key_down_ff   <= key_down_in;
         last_level_ff <= last_level_in;
         low_mark_ff   <= low_mark_in;
         high_mark_ff  <= high_mark_in;
      end
   end

   always_ff @(posedge clock) begin
      event_ff <= event_in;
      level_ff <= level_in;
   end

   // The key state register changes only when a result beat is loaded.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pressed     = key_down_ff;
   assign rsp_press_event = event_ff;
   assign rsp_level       = level_ff;

endmodule

/* rtl/analog_key_rapid_trigger.sv */
// ----------------------------------------------------------------------------
// Analog key rapid trigger
// Turns raw Hall-effect key samples into a travel level and a key state.
//
//   Channel   Direction  Handshake          Payload
//   req_      in         valid / ready      raw_sample
//   rsp_      out        valid / ready      pressed, press_event, level
//   csr_      in         write enable only  index, wdata
//
// One sample per cycle is sustained while rsp_ready is held high; a sample
// passes the input register, the multiply stage and the rule stage that holds the result.
// The rule stage's key state feedback is what bounds one sample per cycle.
// Reset clears all beat valids, the key state and the marks, and loads the
// register reset values. Each stage accepts when empty or when its beat
// moves on, so a held result does not stop the stages behind it filling.
// ----------------------------------------------------------------------------
module analog_key_rapid_trigger (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [akrt_pkg::RawW-1:0]  req_raw_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_pressed,
   output logic                              rsp_press_event,
   output akrt_pkg::level_type               rsp_level,
   input  logic                              csr_wen,
   input  logic [akrt_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [akrt_pkg::CsrDataW-1:0]     csr_wdata
);
   import akrt_pkg::*;

   cfg_type      cfg;
   logic         lvl_valid;
   logic         lvl_ready;
   lvl_beat_type lvl_beat;

   akrt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   akrt_level u_level (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_raw_sample (req_raw_sample),
      .lvl_valid      (lvl_valid),
      .lvl_ready      (lvl_ready),
      .lvl_beat       (lvl_beat)
   );

   akrt_rules u_rules (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .lvl_valid       (lvl_valid),
      .lvl_ready       (lvl_ready),
      .lvl_beat        (lvl_beat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pressed     (rsp_pressed),
      .rsp_press_event (rsp_press_event),
      .rsp_level       (rsp_level)
   );

endmodule

/* rtl/akrt_checker.sv */
// ----------------------------------------------------------------------------
// Analog key rapid trigger port checker
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`include "analog_key_rapid_trigger_defines.svh"

module akrt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_pressed,
   input logic                 rsp_press_event,
   input akrt_pkg::level_type  rsp_level
);
   import akrt_pkg::*;

   localparam logic [1:0] Depth = 2'd3;

   logic [2:0]        count_ff, count_in;
   logic              in_beat, out_beat;
   logic [LevelW+1:0] rsp_payload;

   assign in_beat     = req_valid && req_ready;
   assign out_beat    = rsp_valid && rsp_ready;
   assign count_in    = count_ff + 3'(in_beat) - 3'(out_beat);
   assign rsp_payload = {rsp_pressed, rsp_press_event, rsp_level};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `AKRT_ASSERT_RESET(a_reset_empties, reset, !rsp_valid)
   `AKRT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `AKRT_ASSERT_NOW(a_no_phantom, out_beat, count_ff != '0)
   `AKRT_ASSERT_NOW(a_depth, 1'b1, count_ff <= 3'(Depth))
   `AKRT_ASSERT_NOW(a_ready_when_drained, !rsp_valid, req_ready)

endmodule

bind analog_key_rapid_trigger akrt_checker u_akrt_checker (.*);
